// ----- sv/ict_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the id compaction table.
// No dependencies.
package ict_pkg;

  localparam int ID_W    = 12;
  localparam int CNT_W   = 13;
  localparam int CMD_W   = 2;
  localparam int ST_W    = 2;
  localparam int ID_SPAN = 4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_ASSIGN  = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_REVERSE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_UNMAPPED = 2'd2
  } status_t;

  localparam logic [CNT_W-1:0] RANGE_RESET = CNT_W'(ID_SPAN);

endpackage

// ----- sv/ict_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels of the id compaction table: command items in, result items out.
// Depends on ict_pkg.
interface ict_in_if;
  logic                     valid;
  logic                     ready;
  logic [ict_pkg::CMD_W-1:0] cmd;
  logic [ict_pkg::ID_W-1:0]  vertex_id;

  modport source (output valid, output cmd, output vertex_id, input ready);
  modport sink (input valid, input cmd, input vertex_id, output ready);
endinterface

interface ict_out_if;
  logic                      valid;
  logic                      ready;
  logic [ict_pkg::ID_W-1:0]  result_id;
  logic                      newly_assigned;
  logic [ict_pkg::ST_W-1:0]  status;
  logic [ict_pkg::CNT_W-1:0] assigned_count;

  modport source (output valid, output result_id, output newly_assigned, output status,
                  output assigned_count, input ready);
  modport sink (input valid, input result_id, input newly_assigned, input status,
                input assigned_count, output ready);
endinterface

// ----- sv/ict_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies.
module ict_ram #(
  parameter int W     = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/id_compaction_table_unit.sv -----
`timescale 1ns / 1ps
// Id compaction table: dense renaming of sparse global vertex ids.
// Depends on ict_pkg, ict_if (ict_in_if, ict_out_if) and ict_ram.
//
// When an item is accepted in S_IDLE, the forward table (valid bit plus local id) and
// the reverse table are read; in S_LOOK the item is resolved, a new assignment is
// written and the output register is loaded. A new item is taken while the previous
// result waits at the output only if that result is taken in the same cycle. A clear
// item returns its result at once, then the forward table is swept one entry per
// cycle over all min(TABLE_ENTRIES, 4096) entries, during which no item is accepted.
// The same sweep runs right after reset. Configuration writes are taken in any cycle.
module id_compaction_table_unit #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ict_in_if.sink                    in_ch,
  ict_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [ict_pkg::CNT_W-1:0] cfg_wdata
);

  localparam int DEPTH = (TABLE_ENTRIES > ict_pkg::ID_SPAN) ? ict_pkg::ID_SPAN : TABLE_ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = ict_pkg::ID_W + 1;
  localparam logic [ict_pkg::CNT_W-1:0] DEPTH_CNT = ict_pkg::CNT_W'(DEPTH);
  localparam logic [AW-1:0]             LAST_ROW  = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_LOOK  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [AW-1:0]              clr_cnt_r, clr_cnt_nxt;
  logic [ict_pkg::CNT_W-1:0]  next_local_r, next_local_nxt;
  logic [ict_pkg::CNT_W-1:0]  active_range_r;
  ict_pkg::cmd_t              cmd_r;
  logic [ict_pkg::ID_W-1:0]   id_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [ict_pkg::ID_W-1:0]   res_id_r, res_id_nxt;
  logic                       fresh_r, fresh_nxt;
  ict_pkg::status_t           status_r, status_nxt;

  logic                       fwd_we;
  logic [AW-1:0]              fwd_waddr;
  logic [FW-1:0]              fwd_wdata;
  logic [FW-1:0]              fwd_rdata;
  logic                       rev_we;
  logic [ict_pkg::ID_W-1:0]   rev_rdata;

  logic                       accept;
  logic                       out_take;
  logic [ict_pkg::CNT_W-1:0]  lim;
  logic [ict_pkg::CNT_W-1:0]  id_ext;
  logic                       fwd_valid;
  logic [ict_pkg::ID_W-1:0]   fwd_local;

  assign out_take = out_valid_r & out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) & (~out_valid_r | out_ch.ready);
  assign accept = in_ch.valid & in_ch.ready;

  assign lim = (active_range_r > DEPTH_CNT) ? DEPTH_CNT : active_range_r;
  assign id_ext = {1'b0, id_r};
  assign fwd_valid = fwd_rdata[ict_pkg::ID_W];
  assign fwd_local = fwd_rdata[ict_pkg::ID_W-1:0];

  ict_ram #(.W(FW), .DEPTH(DEPTH)) u_fwd_ram (
    .clk     (clk),
    .wr_en   (fwd_we),
    .wr_addr (fwd_waddr),
    .wr_data (fwd_wdata),
    .rd_addr (in_ch.vertex_id[AW-1:0]),
    .rd_data (fwd_rdata)
  );

  ict_ram #(.W(ict_pkg::ID_W), .DEPTH(DEPTH)) u_rev_ram (
    .clk     (clk),
    .wr_en   (rev_we),
    .wr_addr (next_local_r[AW-1:0]),
    .wr_data (id_r),
    .rd_addr (in_ch.vertex_id[AW-1:0]),
    .rd_data (rev_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    next_local_nxt = next_local_r;
    out_valid_nxt  = out_valid_r & ~out_take;
    res_id_nxt     = res_id_r;
    fresh_nxt      = fresh_r;
    status_nxt     = status_r;
    fwd_we         = 1'b0;
    fwd_waddr      = id_r[AW-1:0];
    fwd_wdata      = {1'b1, next_local_r[ict_pkg::ID_W-1:0]};
    rev_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        res_id_nxt    = '0;
        fresh_nxt     = 1'b0;
        status_nxt    = ict_pkg::ST_OK;
        if (cmd_r == ict_pkg::CMD_CLEAR) begin
          next_local_nxt = '0;
          clr_cnt_nxt    = '0;
          state_nxt      = S_CLEAR;
        end else if (id_ext >= lim) begin
          status_nxt = ict_pkg::ST_RANGE;
        end else begin
          case (cmd_r)
            ict_pkg::CMD_ASSIGN: begin
              if (fwd_valid) begin
                res_id_nxt = fwd_local;
              end else if (next_local_r >= lim) begin
                status_nxt = ict_pkg::ST_RANGE;
              end else begin
                fwd_we         = 1'b1;
                rev_we         = 1'b1;
                res_id_nxt     = next_local_r[ict_pkg::ID_W-1:0];
                fresh_nxt      = 1'b1;
                next_local_nxt = next_local_r + 1'b1;
              end
            end
            ict_pkg::CMD_LOOKUP: begin
              if (fwd_valid) begin
                res_id_nxt = fwd_local;
              end else begin
                status_nxt = ict_pkg::ST_UNMAPPED;
              end
            end
            ict_pkg::CMD_REVERSE: begin
              if (id_ext < next_local_r) begin
                res_id_nxt = rev_rdata;
              end else begin
                status_nxt = ict_pkg::ST_UNMAPPED;
              end
            end
            default: begin
              status_nxt = ict_pkg::ST_OK;
            end
          endcase
        end
      end
      S_CLEAR: begin
        fwd_we      = 1'b1;
        fwd_waddr   = clr_cnt_r;
        fwd_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      next_local_r   <= '0;
      active_range_r <= ict_pkg::RANGE_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      next_local_r <= next_local_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        active_range_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= ict_pkg::cmd_t'(in_ch.cmd);
      id_r  <= in_ch.vertex_id;
    end
    res_id_r <= res_id_nxt;
    fresh_r  <= fresh_nxt;
    status_r <= status_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_id      = res_id_r;
  assign out_ch.newly_assigned = fresh_r;
  assign out_ch.status         = status_r;
  assign out_ch.assigned_count = next_local_r;

endmodule

// ----- test/tb_id_compaction_table_unit.sv -----
`timescale 1ns / 1ps
// Testbench for id_compaction_table_unit: directed and random commands checked against a
// built-in predictor of the global-to-local id table, with random bursts and output stalls.
// Depends on ict_pkg, ict_in_if/ict_out_if and the unit itself.
module tb_id_compaction_table_unit;
  import ict_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    cmd_t            cmd;
    logic [ID_W-1:0] vid;
  } cmd_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  result_id;
    logic             newly_assigned;
    status_t          status;
    logic [CNT_W-1:0] assigned_count;
  } id_result_t;

  typedef struct packed {
    cmd_item_t  src;
    id_result_t res;
  } pending_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid_d = 1'b0;
  logic [CMD_W-1:0] in_cmd_d = '0;
  logic [ID_W-1:0]  in_vid_d = '0;
  logic             rx_ready_d = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  ict_in_if  in_ch ();
  ict_out_if out_ch ();

  assign in_ch.valid     = in_valid_d;
  assign in_ch.cmd       = in_cmd_d;
  assign in_ch.vertex_id = in_vid_d;
  assign out_ch.ready    = rx_ready_d;

  id_compaction_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [ID_W-1:0]  fwd_local [ID_SPAN];
  bit               fwd_valid [ID_SPAN];
  logic [ID_W-1:0]  rev_global [ID_SPAN];
  logic [CNT_W-1:0] next_local = '0;
  logic [CNT_W-1:0] range_copy = RANGE_RESET;

  cmd_item_t       cmd_queue[$];
  pending_result_t expected_results[$];

  bit in_fire = 1'b0;
  bit rx_hold = 1'b0;
  bit hold_go = 1'b0;
  int n_errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_clears = 0;
  int n_fresh = 0;
  int n_full = 0;
  int n_cfg = 0;
  int cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic id_result_t translate_id(cmd_item_t it);
    id_result_t r;
    int lim;
    r = '0;
    r.status = ST_OK;
    lim = (int'(range_copy) > ID_SPAN) ? ID_SPAN : int'(range_copy);
    if (it.cmd == CMD_CLEAR) begin
      foreach (fwd_valid[i]) fwd_valid[i] = 1'b0;
      next_local = '0;
    end else if (int'(it.vid) >= lim) begin
      r.status = ST_RANGE;
    end else begin
      case (it.cmd)
        CMD_ASSIGN: begin
          if (fwd_valid[it.vid]) begin
            r.result_id = fwd_local[it.vid];
          end else if (int'(next_local) >= lim) begin
            r.status = ST_RANGE;
          end else begin
            rev_global[next_local[ID_W-1:0]] = it.vid;
            fwd_local[it.vid] = next_local[ID_W-1:0];
            fwd_valid[it.vid] = 1'b1;
            r.result_id = next_local[ID_W-1:0];
            r.newly_assigned = 1'b1;
            next_local = next_local + 1'b1;
          end
        end
        CMD_LOOKUP: begin
          if (fwd_valid[it.vid]) r.result_id = fwd_local[it.vid];
          else r.status = ST_UNMAPPED;
        end
        default: begin
          if (CNT_W'(it.vid) < next_local) r.result_id = rev_global[it.vid];
          else r.status = ST_UNMAPPED;
        end
      endcase
    end
    r.assigned_count = next_local;
    return r;
  endfunction

  // monitor: checks results, predicts accepted items, tracks register writes
  always @(posedge clk) begin
    pending_result_t exp_r;
    cmd_item_t       it;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("unexpected result: id %0d new %0d status %0d count %0d",
                     out_ch.result_id, out_ch.newly_assigned, out_ch.status,
                     out_ch.assigned_count);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.result_id !== exp_r.res.result_id ||
              out_ch.newly_assigned !== exp_r.res.newly_assigned ||
              out_ch.status !== exp_r.res.status ||
              out_ch.assigned_count !== exp_r.res.assigned_count) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("mismatch %s id %0d: exp %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                       exp_r.src.cmd.name(), exp_r.src.vid, exp_r.res.result_id,
                       exp_r.res.newly_assigned, exp_r.res.status, exp_r.res.assigned_count,
                       out_ch.result_id, out_ch.newly_assigned, out_ch.status,
                       out_ch.assigned_count);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        it.cmd = cmd_t'(in_ch.cmd);
        it.vid = in_ch.vertex_id;
        exp_r.src = it;
        exp_r.res = translate_id(it);
        expected_results.push_back(exp_r);
        n_items++;
        if (it.cmd == CMD_CLEAR) n_clears++;
        if (exp_r.res.newly_assigned) n_fresh++;
        if (it.cmd == CMD_ASSIGN && exp_r.res.status == ST_RANGE && int'(it.vid) < int'(range_copy))
          n_full++;
      end
      if (cfg_we) begin
        range_copy = cfg_wdata;
        n_cfg++;
      end
    end
    in_fire = rst_n && in_ch.valid && in_ch.ready;
  end

  // driver: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    bit send;
    if (in_fire) begin
      void'(cmd_queue.pop_front());
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else if (gap_left > 0) begin
      gap_left--;
    end
    send = rst_n && gap_left == 0 && cmd_queue.size() > 0;
    in_valid_d <= send;
    if (send) begin
      in_cmd_d <= cmd_queue[0].cmd;
      in_vid_d <= cmd_queue[0].vid;
    end else begin
      in_cmd_d <= CMD_W'($urandom);
      in_vid_d <= ID_W'($urandom);
    end
  end

  // receiver: ready pattern redrawn at random from four stall modes
  int rx_cycle = 0;
  int rx_mode = 0;
  always @(negedge clk) begin
    bit rdy;
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 9) < 7);
      2: rdy = (rx_cycle % 4 != 0);
      default: rdy = (rx_cycle % 8 < 2);
    endcase
    rx_ready_d <= rdy && !rx_hold;
  end

  // long output hold-off so the unit backs up onto its input
  initial begin
    wait (hold_go);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(negedge clk);
    rx_hold <= 1'b0;
  end

  task automatic push_cmd(cmd_t c, int v);
    cmd_item_t it;
    it.cmd = c;
    it.vid = ID_W'(v);
    cmd_queue.push_back(it);
  endtask

  task automatic drain();
    while (cmd_queue.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_range(int v);
    drain();
    cfg_wdata <= CNT_W'(v);
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int phase_ranges[10] = '{4096, 16, 1, 300, 64, 20, 4096, 2048, 8, 4096};
    int id_pool[$];
    int lim, p, gid, c_sel;
    cmd_t c;

    wait (rst_n);
    // reset range, first sight, repeat, unmapped lookup, reverse past count, clear
    push_cmd(CMD_ASSIGN, 0);
    push_cmd(CMD_ASSIGN, 4095);
    push_cmd(CMD_ASSIGN, 0);
    push_cmd(CMD_LOOKUP, 4095);
    push_cmd(CMD_LOOKUP, 7);
    push_cmd(CMD_REVERSE, 0);
    push_cmd(CMD_REVERSE, 1);
    push_cmd(CMD_REVERSE, 2);
    push_cmd(CMD_REVERSE, 4095);
    push_cmd(CMD_ASSIGN, 'hAAA);
    push_cmd(CMD_ASSIGN, 'h555);
    push_cmd(CMD_CLEAR, 0);
    push_cmd(CMD_LOOKUP, 0);
    push_cmd(CMD_REVERSE, 0);
    push_cmd(CMD_ASSIGN, 4095);
    // zero range: every item but the clear is out of range
    write_range(0);
    push_cmd(CMD_ASSIGN, 5);
    push_cmd(CMD_LOOKUP, 0);
    push_cmd(CMD_REVERSE, 0);
    push_cmd(CMD_CLEAR, 0);
    // map two ids, then shrink the range below an existing mapping so the table is full
    write_range(3);
    push_cmd(CMD_ASSIGN, 2);
    push_cmd(CMD_ASSIGN, 0);
    write_range(2);
    push_cmd(CMD_ASSIGN, 1);
    push_cmd(CMD_LOOKUP, 2);
    push_cmd(CMD_REVERSE, 1);
    push_cmd(CMD_REVERSE, 2);

    foreach (phase_ranges[ph]) begin
      write_range(phase_ranges[ph]);
      lim = phase_ranges[ph];
      if (ph == 6) hold_go = 1'b1;
      for (int k = 0; k < 83; k++) begin
        p = $urandom_range(0, 99);
        if (p < 45 && id_pool.size() > 0) gid = id_pool[$urandom_range(0, id_pool.size() - 1)];
        else if (p < 85 && lim > 0) gid = $urandom_range(0, lim - 1);
        else gid = $urandom_range(0, ID_SPAN - 1);
        c_sel = $urandom_range(0, 99);
        if (c_sel < 2) begin
          c = CMD_CLEAR;
          gid = $urandom_range(0, ID_SPAN - 1);
          id_pool.delete();
        end else if (c_sel < 50) begin
          c = CMD_ASSIGN;
          id_pool.push_back(gid);
          if (id_pool.size() > 64) void'(id_pool.pop_front());
        end else if (c_sel < 75) begin
          c = CMD_LOOKUP;
        end else begin
          c = CMD_REVERSE;
          if ($urandom_range(0, 9) != 0) gid = $urandom_range(0, id_pool.size() + 3);
        end
        push_cmd(c, gid);
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (expected_results.size() != 0) n_errors += expected_results.size();
    $display("%0d commands (%0d clears, %0d fresh ids, %0d table-full refusals), %0d results",
             n_items, n_clears, n_fresh, n_full, n_results);
    $display("%0d range settings incl. 0, 1 and 4096; %0d errors", n_cfg, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ict_pkg.sv
sv/ict_if.sv
sv/ict_ram.sv
sv/id_compaction_table_unit.sv
test/tb_id_compaction_table_unit.sv
